### rtl/core/fra_pkg.sv
// Shared constants and control types for the fragment run allocator.
package fra_pkg;

  localparam int NUM_FRAGS_DEF = 31;
  localparam int REQ_W         = 5;
  localparam int OUT_W         = 5;

  typedef struct packed {
    logic clear;
    logic step;
    logic slot_free;
  } scan_ctrl_t;

  typedef struct packed {
    logic last;
  } scan_stat_t;

endpackage

### rtl/core/fra_scan.sv
// Run tracker: walks the map one slot per cycle while step is set and keeps the longest free run.
module fra_scan #(
  parameter int NUM_FRAGS = fra_pkg::NUM_FRAGS_DEF,
  parameter int PW        = $clog2(NUM_FRAGS + 1)
) (
  input  logic                clk,
  input  fra_pkg::scan_ctrl_t ctrl,
  output fra_pkg::scan_stat_t stat,
  output logic [PW-1:0]       pos,
  output logic [PW-1:0]       best_start,
  output logic [PW-1:0]       best_len
);
  import fra_pkg::*;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] cur_start_r, cur_start_nxt;
  logic [PW-1:0] cur_len_r, cur_len_nxt;
  logic [PW-1:0] best_start_r, best_start_nxt;
  logic [PW-1:0] best_len_r, best_len_nxt;
  logic [PW-1:0] len_inc;
  logic [PW-1:0] run_start;

  // single incrementer and compare shared by every slot of the walk
  assign len_inc   = cur_len_r + PW'(1);
  assign run_start = (cur_len_r == '0) ? pos_r : cur_start_r;

  always_comb begin
    pos_nxt        = pos_r;
    cur_start_nxt  = cur_start_r;
    cur_len_nxt    = cur_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    if (ctrl.clear) begin
      pos_nxt        = '0;
      cur_start_nxt  = '0;
      cur_len_nxt    = '0;
      best_start_nxt = PW'(NUM_FRAGS);
      best_len_nxt   = '0;
    end else if (ctrl.step) begin
      pos_nxt = pos_r + PW'(1);
      if (ctrl.slot_free) begin
        cur_start_nxt = run_start;
        cur_len_nxt   = len_inc;
        // strict greater: ties keep the lower run
        if (len_inc > best_len_r) begin
          best_len_nxt   = len_inc;
          best_start_nxt = run_start;
        end
      end else begin
        cur_len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    cur_start_r  <= cur_start_nxt;
    cur_len_r    <= cur_len_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
  end

  assign pos        = pos_r;
  assign best_start = best_start_r;
  assign best_len   = best_len_r;
  assign stat.last  = (pos_r == PW'(NUM_FRAGS - 1));

endmodule

### rtl/core/fragment_run_allocator_top.sv
// Top level of the fragment run allocator: slot map, sequencer and result register.
// Keeps a used bit for each of NUM_FRAGS slots, all free after reset. Each
// request (request_count) is answered by one result: the longest free run
// (lowest start on ties), its length before marking, and a grant flag. A
// granted request marks the first request_count slots of that run used; a
// count of zero only queries; a count larger than the run is refused and
// leaves the map alone. With no free slot run_start reads NUM_FRAGS and
// run_length 0. start and length are 5 bits and wrap when NUM_FRAGS > 31.
// Sequence: a transfer clears the run tracker, which then looks at one slot
// per cycle over the whole map before the commit writes the result
// register. in_ready is high only while the sequencer is idle; the result
// register lets the next request be taken while a result waits on
// out_ready, but the commit of a request waits until that register is free.
module fragment_run_allocator_top #(
  parameter int NUM_FRAGS = fra_pkg::NUM_FRAGS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [fra_pkg::REQ_W-1:0] in_request_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_granted,
  output logic [fra_pkg::OUT_W-1:0] out_run_start,
  output logic [fra_pkg::OUT_W-1:0] out_run_length
);
  import fra_pkg::*;

  localparam int PW = $clog2(NUM_FRAGS + 1);
  localparam int IW = (NUM_FRAGS > 1) ? $clog2(NUM_FRAGS) : 1;
  localparam int LW = (PW > REQ_W) ? PW : REQ_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [NUM_FRAGS-1:0] map_r, map_nxt;
  logic [REQ_W-1:0]     want_r, want_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 granted_r, granted_nxt;
  logic [OUT_W-1:0]     start_r, start_nxt;
  logic [OUT_W-1:0]     len_r, len_nxt;

  scan_ctrl_t           sc_ctrl;
  scan_stat_t           sc_stat;
  logic [PW-1:0]        sc_pos;
  logic [PW-1:0]        best_start;
  logic [PW-1:0]        best_len;

  logic                 in_fire;
  logic                 commit;
  logic                 grant;
  logic [LW:0]          run_end;
  logic [NUM_FRAGS-1:0] mark_mask;

  assign in_fire = in_valid && in_ready;
  // result register must be empty (or emptying) before the commit
  assign commit  = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);
  assign grant   = LW'(want_r) <= LW'(best_len);
  assign run_end = (LW + 1)'(best_start) + (LW + 1)'(want_r);

  always_comb begin
    for (int i = 0; i < NUM_FRAGS; i++) begin
      mark_mask[i] = ((LW + 1)'(i) >= (LW + 1)'(best_start)) &&
                     ((LW + 1)'(i) < run_end);
    end
  end

  fra_scan #(
    .NUM_FRAGS (NUM_FRAGS),
    .PW        (PW)
  ) u_scan (
    .clk        (clk),
    .ctrl       (sc_ctrl),
    .stat       (sc_stat),
    .pos        (sc_pos),
    .best_start (best_start),
    .best_len   (best_len)
  );

  always_comb begin
    sc_ctrl.clear     = in_fire;
    sc_ctrl.step      = (state_r == ST_SCAN);
    sc_ctrl.slot_free = !map_r[sc_pos[IW-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    map_nxt       = map_r;
    want_nxt      = want_r;
    out_valid_nxt = out_valid_r;
    granted_nxt   = granted_r;
    start_nxt     = start_r;
    len_nxt       = len_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          want_nxt  = in_request_count;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc_stat.last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          granted_nxt   = grant;
          start_nxt     = OUT_W'(best_start);
          len_nxt       = OUT_W'(best_len);
          if (grant) begin
            map_nxt = map_r | mark_mask;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
    end
    want_r    <= want_nxt;
    granted_r <= granted_nxt;
    start_r   <= start_nxt;
    len_r     <= len_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_granted    = granted_r;
  assign out_run_start  = start_r;
  assign out_run_length = len_r;

`ifndef SYNTHESIS
  // a request never overlaps the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("request taken while scan in progress");

  // a grant only claims slots that were free
  a_mark_free_only: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && grant) |-> ((map_r & mark_mask) == '0))
    else $error("grant marks a used slot");

  // full map leaves no run
  a_full_map: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_COMMIT) && (&map_r)) |->
      ((best_len == '0) && (best_start == PW'(NUM_FRAGS))))
    else $error("run found in full map");

  // tracker never reports a run longer than the map
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |-> (LW'(best_len) <= LW'(NUM_FRAGS)))
    else $error("run length beyond map size");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the fragment run allocator: stimulus, predictor and scoreboard.
`timescale 1ns / 1ps

module tb;
  import fra_pkg::*;

  localparam int SLOTS          = NUM_FRAGS_DEF;
  // No transfer on either side for this many cycles means the block is hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Receiver hold-off used to back the block up; well under the watchdog.
  localparam int HOLD_OFF_CYCLES = 400;
  // Drain wait after the last result; it grows with SLOTS.
  localparam int DRAIN_CYCLES   = 4 * (SLOTS + 2);

  typedef struct packed {
    logic             granted;
    logic [OUT_W-1:0] run_start;
    logic [OUT_W-1:0] run_length;
  } alloc_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [REQ_W-1:0] in_request_count;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_granted;
  logic [OUT_W-1:0] out_run_start;
  logic [OUT_W-1:0] out_run_length;

  // Predictor copy of the used-slot map; bit i set means slot i is taken.
  logic [SLOTS-1:0] slot_used;
  // Allocation results predicted at each request transfer, oldest first.
  alloc_result_t    pending_allocs[$];
  alloc_result_t    oldest_alloc;
  int               mismatch_count = 0;

  // Both sides drop their random idling while this is set.
  logic             steady = 1'b0;
  // Hold-off handshake between the test sequence and the receiver process:
  // the sequence bumps hold_requests, the receiver notices and counts down.
  int               hold_requests = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  int               stall_cycles;

  fragment_run_allocator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_request_count(in_request_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_granted     (out_granted),
    .out_run_start   (out_run_start),
    .out_run_length  (out_run_length)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Predictor: find the longest free run (lowest start wins a tie), then
  // take the first count slots of it if the count fits. A count of zero
  // always fits and takes nothing. With no free slot the start reads SLOTS.
  function automatic alloc_result_t allocate_slots(input logic [REQ_W-1:0] count);
    int            best_start;
    int            best_len;
    int            run_first;
    int            run_len;
    alloc_result_t res;
    best_start = SLOTS;
    best_len   = 0;
    run_first  = 0;
    run_len    = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) begin
        if (run_len == 0) run_first = i;
        run_len++;
        // strictly longer only, so an earlier run of equal length stays
        if (run_len > best_len) begin
          best_len   = run_len;
          best_start = run_first;
        end
      end else begin
        run_len = 0;
      end
    end
    res.granted = (int'(count) <= best_len);
    if (res.granted) begin
      for (int k = 0; k < int'(count); k++) begin
        if (best_start + k < SLOTS) slot_used[best_start + k] = 1'b1;
      end
    end
    res.run_start  = OUT_W'(best_start);
    res.run_length = OUT_W'(best_len);
    return res;
  endfunction

  // Sender: called at a falling edge, returns at the falling edge after the
  // transfer. Valid stays up between back-to-back requests.
  task automatic send_request(input logic [REQ_W-1:0] count);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_request_count = count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_allocs.push_back(allocate_slots(count));
    @(negedge clk);
  endtask

  // Receiver: ready changes on the falling edge only.
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (steady) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(99) >= 35);
    end
  end

  // Scoreboard: every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_allocs.size() == 0) begin
        $error("unexpected result: granted %0d, run_start %0d, run_length %0d",
               out_granted, out_run_start, out_run_length);
        mismatch_count++;
      end else begin
        oldest_alloc = pending_allocs.pop_front();
        if (out_granted !== oldest_alloc.granted) begin
          $error("granted: expected %0d, actual %0d", oldest_alloc.granted, out_granted);
          mismatch_count++;
        end
        if (out_run_start !== oldest_alloc.run_start) begin
          $error("run_start: expected %0d, actual %0d",
                 oldest_alloc.run_start, out_run_start);
          mismatch_count++;
        end
        if (out_run_length !== oldest_alloc.run_length) begin
          $error("run_length: expected %0d, actual %0d",
                 oldest_alloc.run_length, out_run_length);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any stretch with no transfer on either side that reaches the
  // limit ends the run as a failure.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Empty map: a query sees one run covering every slot.
  task automatic test_empty_query();
    send_request('0);
  endtask

  // Each of the four low count bits alone; the map fills from the low end, 15 slots taken.
  task automatic test_power_of_two_grants();
    send_request(REQ_W'(1));
    send_request(REQ_W'(2));
    send_request(REQ_W'(4));
    send_request(REQ_W'(8));
  endtask

  // Counts above the longest run are refused and leave the map alone;
  // the trailing query shows the run unchanged.
  task automatic test_oversize_refusal();
    send_request(REQ_W'(17));
    send_request('1);
    send_request('0);
  endtask

  // Receiver stops for a long stretch while small requests keep coming,
  // so the result register and the sequencer both fill and in_ready drops.
  task automatic test_receiver_hold_off();
    hold_requests++;
    for (int n = 0; n < 20; n++) send_request(REQ_W'($urandom_range(1)));
  endtask

  // Mostly requests that fit the remaining run, mixed with queries and
  // arbitrary counts, until every slot is taken.
  task automatic test_random_fill();
    int free_slots;
    free_slots = SLOTS - $countones(slot_used);
    while (free_slots > 0) begin
      case ($urandom_range(9))
        0, 1:    send_request('0);
        2, 3, 4: send_request(REQ_W'($urandom_range(31)));
        default: send_request(REQ_W'($urandom_range(free_slots, 1)));
      endcase
      free_slots = SLOTS - $countones(slot_used);
    end
  endtask

  // Full map: start reads SLOTS, length 0, only a zero count is granted.
  task automatic test_full_map();
    send_request('0);
    send_request(REQ_W'(1));
    send_request('1);
    send_request(REQ_W'(16));
  endtask

  // Back-to-back stream with both sides always ready.
  task automatic test_steady_stream();
    steady = 1'b1;
    for (int n = 0; n < 200; n++) send_request(REQ_W'($urandom_range(31)));
    steady = 1'b0;
  endtask

  // Random counts with random idling on both sides.
  task automatic test_random_requests();
    for (int n = 0; n < 690; n++) begin
      if ($urandom_range(3) == 0) send_request('0);
      else send_request(REQ_W'($urandom_range(31)));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_request_count = '0;
    slot_used        = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_empty_query();
    test_power_of_two_grants();
    test_oversize_refusal();
    test_receiver_hold_off();
    test_random_fill();
    test_full_map();
    test_steady_stream();
    test_random_requests();
    in_valid = 1'b0;

    // Let every predicted result come back, then watch for strays.
    while (pending_allocs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fra_pkg.sv
rtl/core/fra_scan.sv
rtl/core/fragment_run_allocator_top.sv
tb/tb.sv
